FILE: rtl/vwd_pkg.sv
// ----------------------------------------------------------------------------
// vwd_pkg
// Shared widths, types and helpers for the vertex weld/dedup block.
// ----------------------------------------------------------------------------
package vwd_pkg;

   // Table size and the widths that follow from it.
   localparam int MAX_VERTICES = 256;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);

   // Fixed field widths.
   localparam int COORD_W = 32;
   localparam int VERT_W  = 3 * COORD_W;
   localparam int TOL_W   = 31;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * TOL_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int IDX_W   = 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // latch a new vertex and restart the scan
      logic issue;   // read the next table entry into the distance pipeline
      logic commit;  // settle the result and write the output register
   } vwd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;      // no kept entries
      logic scan_last;  // the entry being issued is the last kept one
      logic found;      // a close entry has been seen
      logic pipe_busy;  // reads are still in flight in the distance pipeline
   } vwd_status_type;

   // Low index bits of a table position, zero-extended for small tables.
   function automatic logic [IDX_W-1:0] to_index(input logic [COUNT_W-1:0] value);
      logic [COUNT_W+IDX_W-1:0] wide;
      wide = {{IDX_W{1'b0}}, value};
      return wide[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/vwd_ram.sv
// ----------------------------------------------------------------------------
// vwd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/vwd_ctrl.sv
// ----------------------------------------------------------------------------
// vwd_ctrl
// Sequencer for one vertex: accept, scan the table, drain, report.
// ----------------------------------------------------------------------------
module vwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output vwd_pkg::vwd_cmd_type    cmd,
   input  vwd_pkg::vwd_status_type status
);
   import vwd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   // The output register can take a result when empty or being emptied.
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // Commands.
   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.issue  = (state_ff == ST_SCAN) && !status.empty && !status.found;
      cmd.commit = (state_ff == ST_REPORT) && out_free;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.empty || status.found || status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid flag.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.commit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

FILE: rtl/vwd_dp.sv
// ----------------------------------------------------------------------------
// vwd_dp
// Datapath: vertex table, scan counter, squared-distance pipeline and the
// result register.
// ----------------------------------------------------------------------------
module vwd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [vwd_pkg::VERT_W-1:0]    req_tdata,
   input  logic                          req_tuser,
   input  logic                          csr_wr_en,
   input  logic [vwd_pkg::TOL_W-1:0]     csr_wr_data,
   input  vwd_pkg::vwd_cmd_type           cmd,
   output vwd_pkg::vwd_status_type        status,
   output logic [vwd_pkg::IDX_W-1:0]      rsp_index,
   output logic                          rsp_is_new,
   output logic                          rsp_full
);
   import vwd_pkg::*;

   // Configuration and vertex under test.
   logic [TOL_W-1:0]   tol_ff;
   logic [SQ_W-1:0]    tol_sq_ff;
   logic [VERT_W-1:0]  vert_ff;

   // Table bookkeeping.
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] scan_addr_ff;
   logic [COUNT_W-1:0] scan_next;
   logic               table_full;
   logic               ram_wr_en;
   logic [VERT_W-1:0]  ram_rd_data;

   // Distance pipeline.
   logic                 v0_ff, v1_ff, v2_ff, v3_ff;
   logic [COUNT_W-1:0]   i0_ff, i1_ff, i2_ff, i3_ff;
   logic signed [DIFF_W-1:0] dx, dy, dz;
   logic [DIFF_W-1:0]    ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]      sqx_ff, sqy_ff, sqz_ff;
   logic                 far2_ff, far3_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic                 hit;

   // Match capture.
   logic               found_ff;
   logic [COUNT_W-1:0] found_idx_ff;

   // Result register.
   logic [IDX_W-1:0]   rsp_index_ff;
   logic               rsp_is_new_ff;
   logic               rsp_full_ff;

   assign scan_next  = scan_addr_ff + COUNT_W'(1);
   assign table_full = (count_ff == COUNT_W'(MAX_VERTICES));
   assign ram_wr_en  = cmd.commit && !found_ff && !table_full;

   // Status back to the controller.
   always_comb begin
      status           = '0;
      status.empty     = (count_ff == '0);
      status.scan_last = (scan_next == count_ff);
      status.found     = found_ff;
      status.pipe_busy = v0_ff | v1_ff | v2_ff | v3_ff;
   end

   // Tolerance register and its square.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      tol_sq_ff <= SQ_W'(tol_ff) * SQ_W'(tol_ff);
   end

   // Latch the incoming vertex.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vert_ff <= req_tdata;
      end
   end

   // Kept-entry count and scan address.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_addr_ff <= '0;
      end else begin
         if (cmd.load) begin
            scan_addr_ff <= '0;
            if (req_tuser) count_ff <= '0;
         end else begin
            if (cmd.issue) scan_addr_ff <= scan_next;
            if (ram_wr_en) count_ff <= count_ff + COUNT_W'(1);
         end
      end
   end

   // Vertex table: x in the low word, then y, then z.
   vwd_ram #(
      .WIDTH (VERT_W),
      .DEPTH (MAX_VERTICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (vert_ff),
      .rd_en   (cmd.issue),
      .rd_addr (scan_addr_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Signed axis differences.
   always_comb begin
      dx = $signed({vert_ff[COORD_W-1], vert_ff[COORD_W-1:0]})
         - $signed({ram_rd_data[COORD_W-1], ram_rd_data[COORD_W-1:0]});
      dy = $signed({vert_ff[2*COORD_W-1], vert_ff[2*COORD_W-1:COORD_W]})
         - $signed({ram_rd_data[2*COORD_W-1], ram_rd_data[2*COORD_W-1:COORD_W]});
      dz = $signed({vert_ff[3*COORD_W-1], vert_ff[3*COORD_W-1:2*COORD_W]})
         - $signed({ram_rd_data[3*COORD_W-1], ram_rd_data[3*COORD_W-1:2*COORD_W]});
   end

   // Pipeline valid bits and index tags.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      i0_ff <= scan_addr_ff;
      i1_ff <= i0_ff;
      i2_ff <= i1_ff;
      i3_ff <= i2_ff;
   end

   // Stage one: absolute differences.
   always_ff @(posedge clock) begin
      ax_ff <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ay_ff <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      az_ff <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
   end

   // Stage two: far test per axis and the three squares. A near axis is
   // below the tolerance, so its low bits hold the whole difference.
   always_ff @(posedge clock) begin
      far2_ff <= (ax_ff >= {2'b00, tol_ff}) || (ay_ff >= {2'b00, tol_ff})
              || (az_ff >= {2'b00, tol_ff});
      sqx_ff  <= SQ_W'(ax_ff[TOL_W-1:0]) * SQ_W'(ax_ff[TOL_W-1:0]);
      sqy_ff  <= SQ_W'(ay_ff[TOL_W-1:0]) * SQ_W'(ay_ff[TOL_W-1:0]);
      sqz_ff  <= SQ_W'(az_ff[TOL_W-1:0]) * SQ_W'(az_ff[TOL_W-1:0]);
   end

   // Stage three: sum of squares.
   always_ff @(posedge clock) begin
      far3_ff <= far2_ff;
      sum_ff  <= {2'b00, sqx_ff} + {2'b00, sqy_ff} + {2'b00, sqz_ff};
   end

   // Final compare against the squared tolerance.
   assign hit = v3_ff && !far3_ff && (sum_ff < {2'b00, tol_sq_ff});

   // Keep the first close entry; entries leave the pipeline in table order.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (hit && !found_ff) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hit && !found_ff) begin
         found_idx_ff <= i3_ff;
      end
   end

   // Result register: match, append or full.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (found_ff) begin
            rsp_index_ff  <= to_index(found_idx_ff);
            rsp_is_new_ff <= 1'b0;
            rsp_full_ff   <= 1'b0;
         end else if (table_full) begin
            rsp_index_ff  <= '0;
            rsp_is_new_ff <= 1'b0;
            rsp_full_ff   <= 1'b1;
         end else begin
            rsp_index_ff  <= to_index(count_ff);
            rsp_is_new_ff <= 1'b1;
            rsp_full_ff   <= 1'b0;
         end
      end
   end

   assign rsp_index  = rsp_index_ff;
   assign rsp_is_new = rsp_is_new_ff;
   assign rsp_full   = rsp_full_ff;

endmodule

FILE: rtl/vertex_weld_dedup.sv
// ----------------------------------------------------------------------------
// vertex_weld_dedup
// Vertex welding: maps each Q16.16 position to the first kept vertex closer
// than the weld tolerance, appends it to the table, or reports a full table.
// ----------------------------------------------------------------------------
// One vertex is handled at a time. After a beat is accepted the block reads
// the kept table one entry per clock through its single RAM read port and a
// four-stage squared-distance pipeline. The scan reads at most 256 entries:
// it ends after the last kept entry, or once a match has been found, and an
// empty table is not read. The result beat is loaded once the pipeline has
// drained. The next beat can be accepted in the cycle after the result is
// loaded, and a result that is still stalled on the output delays only the
// next load. A finished result sits in the output register while the next
// beat is accepted. The table needs no clearing after reset; a beat with
// new_mesh set empties it before its vertex is handled.
module vertex_weld_dedup (
   input  logic                       clock,
   input  logic                       reset,
   // Input vertex.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [vwd_pkg::VERT_W-1:0] req_tdata,   // pos_x, pos_y, pos_z
   input  logic                       req_tuser,   // new_mesh
   // Result.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [vwd_pkg::IDX_W-1:0]  rsp_tdata,   // vertex_index
   output logic [1:0]                 rsp_tuser,   // is_new, table_full
   // Weld tolerance register.
   input  logic                       csr_wr_en,
   input  logic [vwd_pkg::TOL_W-1:0]  csr_wr_data
);
   import vwd_pkg::*;

   vwd_cmd_type    cmd;
   vwd_status_type status;
   logic           rsp_is_new;
   logic           rsp_full;

   vwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   vwd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_index   (rsp_tdata),
      .rsp_is_new  (rsp_is_new),
      .rsp_full    (rsp_full)
   );

   assign rsp_tuser = {rsp_full, rsp_is_new};

endmodule

FILE: rtl/vwd_checker.sv
// ----------------------------------------------------------------------------
// vwd_checker
// Port-level checks for the vertex weld block, bound to the top level.
// ----------------------------------------------------------------------------
module vwd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [vwd_pkg::IDX_W-1:0]  rsp_tdata,
   input logic [1:0]                 rsp_tuser
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // A result is never both appended and rejected for a full table.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("is_new and table_full both set");

   // A full-table result carries index zero.
   a_full_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("full-table result with nonzero index");

   // Only one vertex is in work: the input closes right after a beat.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat accepted while a vertex is in work");

endmodule

bind vertex_weld_dedup vwd_checker u_vwd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/vertex_weld_dedup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_weld_dedup_tb
// Self-checking bench for the vertex welding block. Vertices are streamed in
// bursts while the result side stalls on its own schedule. A behavioral weld
// table in the bench predicts every result, and the block's output is compared
// field by field in arrival order. A short directed table comes first, then
// random phases under several tolerances, including one that fills the table.
// ----------------------------------------------------------------------------
module vertex_weld_dedup_tb;

   localparam int CW          = vwd_pkg::COORD_W;
   localparam int TABLE_DEPTH = vwd_pkg::MAX_VERTICES;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 300;

   // One input beat and one result beat.
   typedef struct packed {
      logic          new_mesh;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
   } vertex_beat_type;

   typedef struct packed {
      logic [vwd_pkg::IDX_W-1:0] vtx_index;
      logic                      is_new;
      logic                      full;
   } weld_result_type;

   // A directed row carries its own expected result when fixed is set.
   typedef struct packed {
      vertex_beat_type beat;
      logic            fixed;
      weld_result_type res;
   } directed_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   localparam int DIRECTED_ROWS = 19;
   localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] N_MIN = 32'h8000_0000;
   localparam logic [31:0] N_ONE = 32'hFFFF_FFFF;

   // Reset tolerance is 1, so only exact copies weld in this table.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{1'b1, 32'd0, 32'd0, 32'd0},    1'b1, '{8'd0, 1'b1, 1'b0}},
      '{'{1'b0, 32'd0, 32'd0, 32'd0},    1'b1, '{8'd0, 1'b0, 1'b0}},
      '{'{1'b0, P_MAX, P_MAX, P_MAX},    1'b1, '{8'd1, 1'b1, 1'b0}},
      '{'{1'b0, N_MIN, N_MIN, N_MIN},    1'b1, '{8'd2, 1'b1, 1'b0}},
      '{'{1'b0, P_MAX, P_MAX, P_MAX},    1'b1, '{8'd1, 1'b0, 1'b0}},
      '{'{1'b0, N_MIN, N_MIN, N_MIN},    1'b1, '{8'd2, 1'b0, 1'b0}},
      '{'{1'b0, 32'd1, 32'd0, 32'd0},    1'b1, '{8'd3, 1'b1, 1'b0}},
      '{'{1'b0, 32'd0, 32'd0, N_ONE},    1'b0, '0},
      '{'{1'b0, N_MIN, P_MAX, 32'd0},    1'b0, '0},
      '{'{1'b0, P_MAX, N_MIN, N_ONE},    1'b0, '0},
      '{'{1'b0, 32'd0, 32'd0, 32'd0},    1'b1, '{8'd0, 1'b0, 1'b0}},
      '{'{1'b0, 32'd1, 32'd0, 32'd0},    1'b1, '{8'd3, 1'b0, 1'b0}},
      '{'{1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000}, 1'b0, '0},
      '{'{1'b1, N_MIN, N_MIN, N_MIN},    1'b1, '{8'd0, 1'b1, 1'b0}},
      '{'{1'b0, 32'd0, 32'd0, 32'd0},    1'b1, '{8'd1, 1'b1, 1'b0}},
      '{'{1'b0, N_MIN, N_MIN, N_MIN},    1'b1, '{8'd0, 1'b0, 1'b0}},
      '{'{1'b1, P_MAX, N_MIN, P_MAX},    1'b1, '{8'd0, 1'b1, 1'b0}},
      '{'{1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
      '{'{1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [vwd_pkg::VERT_W-1:0]   req_tdata   = '0;   // pos_x, pos_y, pos_z
   logic                         req_tuser   = 1'b0; // new_mesh
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [vwd_pkg::IDX_W-1:0]    rsp_tdata;          // vertex_index
   logic [1:0]                   rsp_tuser;          // is_new, table_full
   logic                         csr_wr_en   = 1'b0;
   logic [vwd_pkg::TOL_W-1:0]    csr_wr_data = '0;

   // Behavioral weld table.
   logic [vwd_pkg::TOL_W-1:0] weld_tol = 31'd1;
   logic [CW-1:0] kept_x [TABLE_DEPTH];
   logic [CW-1:0] kept_y [TABLE_DEPTH];
   logic [CW-1:0] kept_z [TABLE_DEPTH];
   int kept_count = 0;

   weld_result_type pending_welds [$];
   directed_row_type row_checks [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int rx_left = 0;
   int rx_phase = 0;

   vertex_weld_dedup dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Absolute difference of two signed coordinates, up to 2^32 - 1.
   function automatic logic [63:0] axis_gap(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic signed [33:0] d;
      d = $signed({{2{a[CW-1]}}, a}) - $signed({{2{b[CW-1]}}, b});
      if (d < 0) d = -d;
      return {30'b0, d};
   endfunction

   // Strict squared-distance test against the current weld tolerance.
   function automatic logic near_entry(input vertex_beat_type v, input int k);
      logic [63:0] tol, dx, dy, dz;
      tol = {33'b0, weld_tol};
      dx = axis_gap(v.x, kept_x[k]);
      dy = axis_gap(v.y, kept_y[k]);
      dz = axis_gap(v.z, kept_z[k]);
      if (dx >= tol || dy >= tol || dz >= tol) return 1'b0;
      return (dx * dx + dy * dy + dz * dz) < (tol * tol);
   endfunction

   // Maps one vertex onto the table and updates it as the block should.
   function automatic weld_result_type weld_vertex(input vertex_beat_type v);
      weld_result_type r;
      logic hit;
      r = '0;
      hit = 1'b0;
      if (v.new_mesh) kept_count = 0;
      for (int k = 0; k < kept_count && !hit; k++) begin
         if (near_entry(v, k)) begin
            r.vtx_index = k[vwd_pkg::IDX_W-1:0];
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (kept_count >= TABLE_DEPTH) begin
            r.full = 1'b1;
         end else begin
            kept_x[kept_count] = v.x;
            kept_y[kept_count] = v.y;
            kept_z[kept_count] = v.z;
            r.vtx_index = kept_count[vwd_pkg::IDX_W-1:0];
            r.is_new = 1'b1;
            kept_count++;
         end
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] nudge(input logic [CW-1:0] base,
                                           input logic [CW-1:0] span);
      logic [CW-1:0] d;
      d = (span == 0) ? '0 : $urandom_range(0, span);
      return $urandom_range(0, 1) ? base - d : base + d;
   endfunction

   function automatic logic [CW-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 32'd1;
         2:       return N_ONE;
         3:       return P_MAX;
         default: return N_MIN;
      endcase
   endfunction

   // Random vertex: mostly neighbors of kept entries, some at the weld edge,
   // the rest random, extreme or small coordinates.
   function automatic vertex_beat_type random_vertex();
      vertex_beat_type v;
      logic [CW-1:0] t, span, edge_off;
      int pick, k;
      t = {1'b0, weld_tol};
      pick = $urandom_range(0, 99);
      v.new_mesh = 1'b0;
      v.x = $urandom;
      v.y = $urandom;
      v.z = $urandom;
      if (pick < 55 && kept_count > 0) begin
         k = $urandom_range(0, kept_count - 1);
         span = ($urandom_range(0, 3) == 0) ? t + (t >> 2) : (t >> 1);
         v.x = nudge(kept_x[k], span);
         v.y = nudge(kept_y[k], span);
         v.z = nudge(kept_z[k], span);
      end else if (pick < 62 && kept_count > 0) begin
         k = $urandom_range(0, kept_count - 1);
         edge_off = t - 1 + $urandom_range(0, 2);
         v.x = kept_x[k];
         v.y = kept_y[k];
         v.z = kept_z[k];
         case ($urandom_range(0, 2))
            0:       v.x = v.x + edge_off;
            1:       v.y = v.y - edge_off;
            default: v.z = v.z + edge_off;
         endcase
      end else if (pick >= 77 && pick < 90) begin
         v.x = extreme_coord();
         v.y = extreme_coord();
         v.z = extreme_coord();
      end else if (pick >= 90) begin
         v.x = 32'($urandom_range(0, 511)) - 32'd256;
         v.y = 32'($urandom_range(0, 511)) - 32'd256;
         v.z = 32'($urandom_range(0, 511)) - 32'd256;
      end
      return v;
   endfunction

   // Presents one beat at the current falling edge and holds it until taken.
   task automatic send_beat(input directed_row_type row);
      req_tvalid <= 1'b1;
      req_tdata  <= {row.beat.z, row.beat.y, row.beat.x};
      req_tuser  <= row.beat.new_mesh;
      row_checks = {row_checks, row};
      do @(posedge clock); while (!req_tready);
   endtask

   // Sender bursts: back-to-back beats, then a random gap.
   task automatic sender_pause();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : $urandom_range(1, 4);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Lowers valid and waits until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_welds.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [vwd_pkg::TOL_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      weld_tol = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One random phase under a fixed tolerance. mesh_rate of 0 never starts
   // a new mesh after the first beat.
   task automatic run_phase(input logic [vwd_pkg::TOL_W-1:0] tol, input int beats,
                            input bit fresh, input int mesh_rate);
      directed_row_type row;
      write_tolerance(tol);
      for (int i = 0; i < beats; i++) begin
         @(negedge clock);
         row = '0;
         row.beat = random_vertex();
         row.beat.new_mesh = (i == 0) ? fresh
                           : (mesh_rate != 0 && $urandom_range(1, mesh_rate) == 1);
         send_beat(row);
         sender_pause();
      end
      drain();
   endtask

   // Receiver stalls: modes switch after a random number of cycles.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= (rx_phase % 8 == 0);
         default:   rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Result check first, then prediction for the beat taken at this edge.
   always @(posedge clock) begin
      weld_result_type want, got;
      directed_row_type row;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1]};
         if (pending_welds.size() == 0) begin
            $display("%0t: unexpected result, expected none, got index %0d new %0b full %0b",
                     $time, got.vtx_index, got.is_new, got.full);
            mismatch_count++;
         end else begin
            want = pending_welds.pop_front();
            if (got.vtx_index !== want.vtx_index) begin
               $display("%0t: vertex_index expected %0d, got %0d",
                        $time, want.vtx_index, got.vtx_index);
               mismatch_count++;
            end
            if (got.is_new !== want.is_new) begin
               $display("%0t: is_new expected %0b, got %0b", $time, want.is_new, got.is_new);
               mismatch_count++;
            end
            if (got.full !== want.full) begin
               $display("%0t: table_full expected %0b, got %0b", $time, want.full, got.full);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         row = row_checks.pop_front();
         want = weld_vertex(vertex_beat_type'{req_tuser, req_tdata[CW-1:0],
                                              req_tdata[2*CW-1:CW],
                                              req_tdata[3*CW-1:2*CW]});
         if (row.fixed) want = row.res;
         pending_welds = {pending_welds, want};
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows under the reset tolerance.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         @(negedge clock);
         send_beat(directed_rows[i]);
         sender_pause();
      end
      drain();

      // Zero tolerance fills the table and runs past full; the next phase starts
      // from the full table under the widest tolerance, with occasional new meshes.
      run_phase(31'd0, 270, 1'b1, 0);
      run_phase(31'h7FFF_FFFF, 50, 1'b0, 25);
      run_phase(31'($urandom_range(1, 32'h0001_0000)), 70, 1'b1, 40);
      run_phase(31'd1, 40, 1'b1, 30);
      run_phase(31'($urandom), 60, 1'b1, 40);

      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && pending_welds.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/vwd_pkg.sv
rtl/vwd_ram.sv
rtl/vwd_ctrl.sv
rtl/vwd_dp.sv
rtl/vertex_weld_dedup.sv
rtl/vwd_checker.sv
tb/vertex_weld_dedup_tb.sv
